FILE: rtl/board_text_to_hex_key_encoder_core_defines.svh
// assertion macros shared by the encoder rtl
`ifndef BOARD_TEXT_TO_HEX_KEY_ENCODER_CORE_DEFINES_SVH
`define BOARD_TEXT_TO_HEX_KEY_ENCODER_CORE_DEFINES_SVH

// checked on every clock edge outside reset
`define BTHK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bthk check failed");

// checked on every clock edge, reset included
`define BTHK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bthk check failed with reset active");

`endif

FILE: rtl/bthk_pkg.sv
`timescale 1ns / 1ps

package bthk_pkg;

  localparam int MAX_OUT_DEFAULT = 92;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } bthk_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_empty;
    logic       out_last;
  } bthk_out_t;

  typedef enum logic [1:0] {
    PH_BOARD = 2'd0,
    PH_SIDE  = 2'd1,
    PH_SKIP  = 2'd2,
    PH_EXTRA = 2'd3
  } bthk_phase_t;

  // piece / run table for the board part
  function automatic logic [7:0] board_code(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      "1":     r = "0";
      "2":     r = "1";
      "3":     r = "2";
      "p":     r = "3";
      "n":     r = "4";
      "b":     r = "5";
      "r":     r = "6";
      "q":     r = "7";
      "k":     r = "9";
      "P":     r = "a";
      "N":     r = "b";
      "B":     r = "c";
      "R":     r = "d";
      "Q":     r = "e";
      "K":     r = "f";
      default: r = "8";
    endcase
    return r;
  endfunction

  // table for castling, en passant and counters
  function automatic logic [7:0] extra_code(input logic [7:0] c);
    logic [7:0] r;
    if (c >= "a" && c <= "h") begin
      r = 8'("1") + (c - 8'("a"));
    end else if (c >= "B" && c <= "G") begin
      r = "e";
    end else begin
      case (c)
        "-":     r = "0";
        "K":     r = "a";
        "Q":     r = "b";
        "k":     r = "c";
        "q":     r = "d";
        " ":     r = "9";
        default: r = c;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: rtl/board_text_to_hex_key_encoder_core.sv
`timescale 1ns / 1ps
`include "board_text_to_hex_key_encoder_core_defines.svh"

// board text to hex key encoder
//
// src channel: one request per text character (in_char, in_last). in_last
// marks the final character of a text; the next request starts a new text.
// dst channel: one request per key character (out_char, out_last, out_empty).
// out_last marks the final key character; an empty key comes out as a single
// request with out_empty and out_last set and out_char zero.
//
// a character is captured in an input register, then encoded in one pass
// into a result group of up to four key characters, which the output side
// hands out one per cycle unless dst stalls. one key character is always
// held back inside the block so the odd-length fix can be applied, so
// results trail the input by one character. a result group is registered
// from the input register once the output side is free. a new character is
// taken every cycle, unless dst stalls, while each character yields at most
// one key character; one yielding more holds the input until its group is out.
// when dst stalls, the current result holds and the input register still
// takes one more character before src sees stall.
// reset (synchronous, active high) empties both registers and returns the
// encoder to the board phase with no characters produced.
module board_text_to_hex_key_encoder_core #(
  parameter int MaxOut = bthk_pkg::MAX_OUT_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  bthk_pkg::bthk_in_t src_req,
  output logic               dst_valid,
  input  logic               dst_stall,
  output bthk_pkg::bthk_out_t dst_req
);
  import bthk_pkg::*;

  localparam int CntW = $clog2(MaxOut + 1);

  // input register
  logic        ir_valid;
  bthk_in_t    ir_data;

  // encoder state
  bthk_phase_t phase, phase_next;
  logic [CntW-1:0] produced_count, produced_count_next;
  logic [7:0]  held_char, held_char_next;
  logic        held_valid, held_valid_next;

  // result group register
  logic [7:0]  grp_char [4];
  logic [2:0]  grp_cnt;
  logic [1:0]  grp_pos;
  logic        grp_last;
  logic        grp_empty;

  // one-pass encode of the character in the input register
  logic [7:0]  w_pend [4];
  logic [2:0]  w_pn;
  logic [7:0]  w_hc;
  logic        w_hv;
  logic [CntW-1:0] w_cnt;
  logic        m1_en, m2_en;
  logic [7:0]  m1, m2, xm;
  logic        room_two;

  logic        grp_pop, grp_done, grp_free, advance;
  logic [7:0]  c;
  logic        c_last;

  assign c      = ir_data.in_char;
  assign c_last = ir_data.in_last;

  // a second character of an expansion needs count + 1 below the limit
  assign room_two = ({1'b0, produced_count} + (CntW+1)'(1)) < (CntW+1)'(MaxOut);

  // handshakes
  assign dst_valid = (grp_cnt != 3'd0);
  assign grp_pop   = dst_valid && !dst_stall;
  assign grp_done  = ({1'b0, grp_pos} == (grp_cnt - 3'd1));
  assign grp_free  = (grp_cnt == 3'd0) || (grp_pop && grp_done);
  assign advance   = ir_valid && grp_free;
  assign src_stall = ir_valid && !grp_free;

  assign dst_req.out_char  = grp_char[grp_pos];
  assign dst_req.out_empty = grp_empty;
  assign dst_req.out_last  = grp_last && grp_done;

  // phase sequencing
  always_comb begin
    phase_next = phase;
    if (advance) begin
      if (c_last) begin
        phase_next = PH_BOARD;
      end else if (produced_count < CntW'(MaxOut)) begin
        case (phase)
          PH_BOARD: begin
            if (c == " ") phase_next = PH_SIDE;
          end
          PH_SIDE:  phase_next = PH_SKIP;
          PH_SKIP:  phase_next = PH_EXTRA;
          PH_EXTRA: phase_next = PH_EXTRA;
          default:  phase_next = PH_BOARD;
        endcase
      end
    end
  end

  // key characters produced by this character, before the hold stage
  always_comb begin
    m1_en = 1'b0;
    m2_en = 1'b0;
    m1    = 8'd0;
    m2    = 8'd0;
    xm    = extra_code(c);
    if (produced_count < CntW'(MaxOut)) begin
      case (phase)
        PH_BOARD: begin
          if (c == " ") begin
            // text ending right after the board still gets a side code
            if (c_last) begin
              m1_en = 1'b1;
              m1    = "0";
            end
          end else if (c != "/") begin
            m1_en = 1'b1;
            m1    = board_code(c);
            // long runs: '8' then the digit minus four
            if (c >= "4" && c <= "8" && room_two) begin
              m2_en = 1'b1;
              m2    = c - 8'd4;
            end
          end
        end
        PH_SIDE: begin
          m1_en = 1'b1;
          m1    = (c == "b") ? 8'("1") : 8'("0");
        end
        PH_SKIP: begin
          m1_en = 1'b0;
        end
        PH_EXTRA: begin
          m1_en = 1'b1;
          m1    = xm;
          // upper-case B-G expand with the code of the lower-case letter
          if (xm == "e" && room_two) begin
            m2_en = 1'b1;
            m2    = extra_code(c + 8'd32);
          end
        end
        default: m1_en = 1'b0;
      endcase
    end
  end

  // hold stage and end-of-text fix
  always_comb begin
    for (int i = 0; i < 4; i++) w_pend[i] = 8'd0;
    w_pn  = 3'd0;
    w_hc  = held_char;
    w_hv  = held_valid;
    w_cnt = produced_count;

    if (m1_en) begin
      if (w_hv) begin
        w_pend[w_pn[1:0]] = w_hc;
        w_pn = w_pn + 3'd1;
      end
      w_hc  = m1;
      w_hv  = 1'b1;
      w_cnt = w_cnt + CntW'(1);
    end
    if (m2_en) begin
      if (w_hv) begin
        w_pend[w_pn[1:0]] = w_hc;
        w_pn = w_pn + 3'd1;
      end
      w_hc  = m2;
      w_hv  = 1'b1;
      w_cnt = w_cnt + CntW'(1);
    end

    if (c_last) begin
      // odd key: drop a trailing '0' or pad with one if there is room
      if (w_cnt[0]) begin
        if (w_hv && w_hc == "0") begin
          w_hv  = 1'b0;
          w_cnt = w_cnt - CntW'(1);
        end else if (w_cnt < CntW'(MaxOut)) begin
          if (w_hv) begin
            w_pend[w_pn[1:0]] = w_hc;
            w_pn = w_pn + 3'd1;
          end
          w_hc  = "0";
          w_hv  = 1'b1;
          w_cnt = w_cnt + CntW'(1);
        end
      end
      if (w_hv) begin
        w_pend[w_pn[1:0]] = w_hc;
        w_pn = w_pn + 3'd1;
      end
    end
  end

  always_comb begin
    produced_count_next = produced_count;
    held_char_next      = held_char;
    held_valid_next     = held_valid;
    if (advance) begin
      if (c_last) begin
        produced_count_next = '0;
        held_char_next      = 8'd0;
        held_valid_next     = 1'b0;
      end else begin
        produced_count_next = w_cnt;
        held_char_next      = w_hc;
        held_valid_next     = w_hv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid       <= 1'b0;
      phase          <= PH_BOARD;
      produced_count <= '0;
      held_char      <= 8'd0;
      held_valid     <= 1'b0;
      grp_cnt        <= 3'd0;
      grp_pos        <= 2'd0;
      grp_last       <= 1'b0;
      grp_empty      <= 1'b0;
    end else begin
      phase          <= phase_next;
      produced_count <= produced_count_next;
      held_char      <= held_char_next;
      held_valid     <= held_valid_next;

      if (src_valid && !src_stall) begin
        ir_valid <= 1'b1;
      end else if (advance) begin
        ir_valid <= 1'b0;
      end

      if (grp_free) begin
        grp_pos <= 2'd0;
        if (advance) begin
          // empty key still yields one marked request
          grp_cnt   <= (c_last && w_pn == 3'd0) ? 3'd1 : w_pn;
          grp_last  <= c_last;
          grp_empty <= c_last && (w_pn == 3'd0);
        end else begin
          grp_cnt   <= 3'd0;
          grp_last  <= 1'b0;
          grp_empty <= 1'b0;
        end
      end else if (grp_pop) begin
        grp_pos <= grp_pos + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      ir_data <= src_req;
    end
    if (advance) begin
      for (int i = 0; i < 4; i++) grp_char[i] <= w_pend[i];
    end
  end

  // checks
  `BTHK_ASSERT(a_pos_in_group, (grp_cnt != 3'd0) |-> ({1'b0, grp_pos} < grp_cnt))
  `BTHK_ASSERT(a_empty_is_single, (dst_valid && grp_empty) |-> (grp_cnt == 3'd1 && grp_last))
  `BTHK_ASSERT(a_count_bounded, produced_count <= CntW'(MaxOut))
  `BTHK_ASSERT(a_last_restarts, (advance && c_last) |=> (phase == PH_BOARD && !held_valid && produced_count == '0))
  `BTHK_ASSERT_ALWAYS(a_reset_clears, rst |=> (!ir_valid && grp_cnt == 3'd0))

endmodule
